// ===== rtl/lsfw_pkg.sv =====
package lsfw_pkg;

    localparam int unsigned FRAME_BITS = 28;
    localparam int unsigned POS_W      = 5;

    // Row base addresses of the four display lines
    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

    typedef enum logic [1:0] {
        CMD_CTRL   = 2'd0,
        CMD_DATA   = 2'd1,
        CMD_CURSOR = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] byte_value;
        logic [2:0] row;
        logic [3:0] column;
    } t_in_beat;

    typedef struct packed {
        logic             serial_bit;
        logic [POS_W-1:0] bit_position;
        logic             last;
    } t_out_beat;

    // Classified command: register select and the byte to send
    typedef struct packed {
        logic       rs;
        logic [7:0] data;
    } t_frame;

    function automatic logic frame_bit(input t_frame frame, input logic [POS_W-1:0] pos);
        logic [FRAME_BITS-1:0] word;
        logic [POS_W-1:0]      idx;
        word = {5'b11111, 1'b0, frame.rs, 1'b0, frame.data[7:4], 4'b0000,
                frame.data[3:0], 8'h00};
        idx  = POS_W'(FRAME_BITS - 1) - pos;
        return word[idx];
    endfunction

endpackage

// ===== rtl/lsfw_front.sv =====
module lsfw_front
    import lsfw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_beat i_item,
    output logic     o_valid,
    output t_frame   o_frame,
    input  logic     i_ready
);

    logic   r_valid;
    t_frame r_frame;
    t_frame n_frame;
    logic   n_keep;
    logic   take;
    logic [1:0] row_c;
    logic [2:0] col_c;

    assign o_full  = r_valid && !i_ready;
    assign take    = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_frame = r_frame;

    always_comb begin
        row_c   = (i_item.row > 3'd3) ? 2'd3 : i_item.row[1:0];
        col_c   = (i_item.column > 4'd7) ? 3'd7 : i_item.column[2:0];
        n_keep  = 1'b1;
        n_frame = '{rs: 1'b0, data: i_item.byte_value};
        case (t_cmd'(i_item.cmd))
            CMD_CTRL: begin
                n_frame.rs = 1'b0;
            end
            CMD_DATA: begin
                n_frame.rs = 1'b1;
            end
            CMD_CURSOR: begin
                // column stays below 8, so the base's low bits are free
                n_frame.data = ROW_BASE[row_c] | {5'b00000, col_c};
            end
            default: begin
                // drop the undefined command
                n_keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= n_keep;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frame <= n_frame;
        end
    end

endmodule

// ===== rtl/lsfw_queue.sv =====
module lsfw_queue
    import lsfw_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_en,
    output logic   o_wr_ready,
    input  t_frame i_wr_data,
    output logic   o_rd_valid,
    input  logic   i_rd_en,
    output t_frame o_rd_data
);

    t_frame     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic       wr;
    logic       rd;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd];
    assign wr         = i_wr_en && o_wr_ready;
    assign rd         = i_rd_en && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (wr) begin
                r_wr <= ~r_wr;
            end
            if (rd) begin
                r_rd <= ~r_rd;
            end
            case ({wr, rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue fill count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== rtl/lsfw_back.sv =====
module lsfw_back
    import lsfw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_frame    i_frame,
    output logic      o_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_beat o_result
);

    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    t_frame           r_frame;
    logic             r_out_valid;
    t_out_beat        r_out;
    logic             advance;
    logic             emit;
    logic             at_end;
    t_frame           cur;

    assign advance  = !r_out_valid || i_pop;
    assign emit     = advance && (r_busy || i_valid);
    assign o_take   = advance && !r_busy && i_valid;
    assign cur      = r_busy ? r_frame : i_frame;
    assign at_end   = (r_pos == POS_W'(FRAME_BITS - 1));
    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                if (at_end) begin
                    r_busy <= 1'b0;
                    r_pos  <= '0;
                end else begin
                    r_busy <= 1'b1;
                    r_pos  <= r_pos + POS_W'(1);
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_frame <= i_frame;
        end
        if (emit) begin
            r_out.serial_bit   <= frame_bit(cur, r_pos);
            r_out.bit_position <= r_pos;
            r_out.last         <= at_end;
        end
    end

`ifndef ASSERT_OFF
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && r_out.last) |-> (r_out.bit_position == POS_W'(FRAME_BITS - 1)))
        else $error("last beat not at final frame position");

    a_idle_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pos == '0))
        else $error("bit counter moved while no frame in flight");

    a_next_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !r_out.last) |=>
            (!o_empty && r_out.bit_position == POS_W'($past(r_out.bit_position) + 1)))
        else $error("frame beats not contiguous");
`endif

endmodule

// ===== rtl/lcd_serial_frame_writer.sv =====
// Channel   Handshake          Payload
// command   push / full        i_item   (t_in_beat: cmd, byte_value, row, column)
// result    pop / empty        o_result (t_out_beat: serial_bit, bit_position, last)
//
// Each command yields 28 result beats, one per cycle while pop keeps up; the
// bit shifter in the back end sets the rate. An undefined command is
// dropped at the front and gives no beats.
// A front register and a two-entry queue hold up to three commands while the
// shifter runs. Synchronous active-low reset empties every stage.
// A stall on pop freezes the shifter; full rises once front and queue are taken.
module lcd_serial_frame_writer
    import lsfw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_beat  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_beat o_result
);

    logic   f_valid;
    t_frame f_frame;
    logic   q_ready;
    logic   q_valid;
    t_frame q_frame;
    logic   b_take;

    lsfw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (f_valid),
        .o_frame (f_frame),
        .i_ready (q_ready)
    );

    lsfw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (f_valid),
        .o_wr_ready (q_ready),
        .i_wr_data  (f_frame),
        .o_rd_valid (q_valid),
        .i_rd_en    (b_take),
        .o_rd_data  (q_frame)
    );

    lsfw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_frame  (q_frame),
        .o_take   (b_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule
